>>> rtl/evpnf_pkg.sv
// ----------------------------------------------------------------------------
// Event pixel neighbour filter package
// Shared types and constants for the request path, the command queue and the
// result path.
// ----------------------------------------------------------------------------
`default_nettype none

package evpnf_pkg;

  localparam int CRD_W = 9;
  localparam int CNT_W = 6;
  localparam int CFG_IDX_W = 8;
  localparam logic [15:0] NO_CLUSTER = 16'hFFFF;

  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_ADD = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  localparam logic [1:0] RK_TOTAL = 2'd0;
  localparam logic [1:0] RK_COUNT = 2'd1;
  localparam logic [1:0] RK_ADD = 2'd2;
  localparam logic [1:0] RK_REMOVE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER = 8'd3;

  typedef enum logic [1:0] {
    OP_CHECK = 2'd0,
    OP_ADD = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [31:0] time_value;
    logic [15:0] cluster_id;
  } req_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [15:0]      cluster_out;
    logic [CNT_W-1:0] count_out;
    logic [7:0]       notice_x;
    logic [7:0]       notice_y;
    logic             last_result;
  } res_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       px;
    logic [7:0]       py;
    logic [31:0]      tval;
    logic [15:0]      cid;
    logic [31:0]      fth;
    logic [31:0]      cth;
    logic [CRD_W-1:0] xs;
    logic [CRD_W-1:0] xe;
    logic [CRD_W-1:0] ys;
    logic [CRD_W-1:0] ye;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/evpnf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its
// data while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module evpnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/evpnf_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// Decouples the request front end from the back end, and the back end from
// the result consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module evpnf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/evpnf_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Holds the configuration registers, accepts requests, drops those that do
// nothing, and works out windows and the clipped neighbourhood.
// ----------------------------------------------------------------------------
`default_nettype none

module evpnf_front import evpnf_pkg::*; #(
  parameter int FRAME_WIDTH = 256,
  parameter int FRAME_HEIGHT = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire req_t                 req,
  input  wire logic                 clearing,
  input  wire logic                 q_full,
  output logic                      q_push,
  output cmd_t                      q_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic [8:0] width_in_use;
  logic [8:0] height_in_use;
  logic [31:0] filter_window;
  logic [31:0] cluster_window;
  logic [CRD_W-1:0] wl;
  logic [CRD_W-1:0] hl;
  logic [CRD_W-1:0] xp2;
  logic [CRD_W-1:0] yp2;
  logic in_frame;
  logic keep;

  assign cfg_ready = 1'b1;
  assign full = q_full || clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use <= 9'd256;
      height_in_use <= 9'd256;
      filter_window <= 32'd10000;
      cluster_window <= 32'd10000;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_WIDTH: width_in_use <= cfg_data[8:0];
        CFG_HEIGHT: height_in_use <= cfg_data[8:0];
        CFG_FILTER: filter_window <= cfg_data;
        CFG_CLUSTER: cluster_window <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    wl = (32'(width_in_use) < FRAME_WIDTH) ? width_in_use : CRD_W'(FRAME_WIDTH);
    hl = (32'(height_in_use) < FRAME_HEIGHT) ? height_in_use : CRD_W'(FRAME_HEIGHT);
    xp2 = CRD_W'(req.pixel_x) + CRD_W'(2);
    yp2 = CRD_W'(req.pixel_y) + CRD_W'(2);
    in_frame = (32'(req.pixel_x) < FRAME_WIDTH) && (32'(req.pixel_y) < FRAME_HEIGHT);
    q_data.op = OP_CHECK;
    keep = 1'b0;
    case (req.req_type)
      REQ_CHECK: begin
        q_data.op = OP_CHECK;
        keep = 1'b1;
      end
      REQ_ADD: begin
        q_data.op = OP_ADD;
        keep = in_frame;
      end
      REQ_FLUSH: begin
        q_data.op = OP_FLUSH;
        keep = in_frame;
      end
      default: keep = 1'b0;
    endcase
    q_data.px = req.pixel_x;
    q_data.py = req.pixel_y;
    q_data.tval = req.time_value;
    q_data.cid = req.cluster_id;
    q_data.fth = (req.time_value >= filter_window) ? req.time_value - filter_window : '0;
    q_data.cth = (req.time_value >= cluster_window) ? req.time_value - cluster_window : '0;
    q_data.xs = (req.pixel_x != '0) ? CRD_W'(req.pixel_x) - 1'b1 : '0;
    q_data.ys = (req.pixel_y != '0) ? CRD_W'(req.pixel_y) - 1'b1 : '0;
    q_data.xe = (xp2 > wl) ? wl : xp2;
    q_data.ye = (yp2 > hl) ? hl : yp2;
    q_push = push && !full && keep;
  end

endmodule

`default_nettype wire

>>> rtl/evpnf_back.sv
// ----------------------------------------------------------------------------
// Request back end
// Owns the pixel store, runs the clearing pass after reset, scans
// neighbourhoods into a sorted cluster list, and updates pixel rings.
// ----------------------------------------------------------------------------
`default_nettype none

module evpnf_back import evpnf_pkg::*; #(
  parameter int FRAME_WIDTH = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  output logic      clearing,
  input  wire logic q_empty,
  output logic      q_pop,
  input  wire cmd_t q_data,
  input  wire logic res_full,
  output logic      res_push,
  output res_t      res_data
);

  localparam int PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int ROW_W = HW + QUEUE_DEPTH * 48;
  localparam int ID_BASE = HW + QUEUE_DEPTH * 32;
  localparam int AREA_MAX = 9 * QUEUE_DEPTH;
  localparam int POS_W = $clog2(AREA_MAX + 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RD    = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_NOTE  = 7'b1000000
  } state_t;

  state_t state;
  cmd_t cmd;
  logic [ADDR_W-1:0] clr_addr;
  logic [CRD_W-1:0] cur_x;
  logic [CRD_W-1:0] cur_y;
  logic [HW-1:0] z;
  logic [CNT_W-1:0] total;
  logic [15:0] lid [AREA_MAX];
  logic [CNT_W-1:0] lcnt [AREA_MAX];
  logic [AREA_MAX-1:0] lval;
  logic pend_add;
  logic [QUEUE_DEPTH-1:0] nmask;
  logic [15:0] nid [QUEUE_DEPTH];

  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;
  logic [ROW_W-1:0] mod_row;
  logic [ROW_W-1:0] clr_row;
  logic [ADDR_W-1:0] addr_now;
  logic [ADDR_W-1:0] waddr;
  logic we;
  logic re;
  logic [31:0] rd_ts [QUEUE_DEPTH];
  logic [15:0] rd_id [QUEUE_DEPTH];
  logic [HW-1:0] h_eff;
  logic [HW-1:0] h_next;
  logic [QUEUE_DEPTH-1:0] mod_mask;
  logic [31:0] ts;
  logic [15:0] id;
  logic qualify;
  logic [AREA_MAX-1:0] lt;
  logic [AREA_MAX-1:0] eq;
  logic [POS_W-1:0] pos;
  logic [HW-1:0] sel;
  logic note_last;

  evpnf_ram #(
    .WIDTH(ROW_W),
    .DEPTH(PIXELS)
  ) u_store (
    .clk(clk),
    .we(we),
    .waddr(waddr),
    .wdata(wdata),
    .re(re),
    .raddr(addr_now),
    .rdata(rdata)
  );

  assign clearing = (state == S_CLEAR);
  assign addr_now = ADDR_W'(cur_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(cur_x);
  assign re = (state == S_RD);
  assign q_pop = (state == S_IDLE) && !q_empty;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rd_ts[i] = rdata[HW + i * 32 +: 32];
      rd_id[i] = rdata[ID_BASE + i * 16 +: 16];
    end
    h_eff = (32'(rdata[HW-1:0]) >= QUEUE_DEPTH) ? '0 : rdata[HW-1:0];
    h_next = (32'(h_eff) == QUEUE_DEPTH - 1) ? '0 : h_eff + 1'b1;
    clr_row = '0;
    mod_row = rdata;
    mod_mask = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      clr_row[ID_BASE + i * 16 +: 16] = NO_CLUSTER;
      if (cmd.op == OP_FLUSH) begin
        mod_mask[i] = (rd_id[i] != NO_CLUSTER) && (rd_ts[i] < cmd.tval);
        if (mod_mask[i]) begin
          mod_row[ID_BASE + i * 16 +: 16] = NO_CLUSTER;
        end
      end else if (HW'(i) == h_eff) begin
        mod_mask[i] = (rd_id[i] != NO_CLUSTER);
        mod_row[HW + i * 32 +: 32] = cmd.tval;
        mod_row[ID_BASE + i * 16 +: 16] = cmd.cid;
      end
    end
    if (cmd.op != OP_FLUSH) begin
      mod_row[HW-1:0] = h_next;
    end
    we = (state == S_CLEAR) || (state == S_MOD);
    waddr = (state == S_CLEAR) ? clr_addr : addr_now;
    wdata = (state == S_CLEAR) ? clr_row : mod_row;
  end

  always_comb begin
    ts = rd_ts[z];
    id = rd_id[z];
    qualify = (id != NO_CLUSTER) && (ts > cmd.cth);
    for (int i = 0; i < AREA_MAX; i++) begin
      lt[i] = lval[i] && (lid[i] < id);
      eq[i] = lval[i] && (lid[i] == id);
    end
    pos = POS_W'($countones(lt));
    sel = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (nmask[i]) begin
        sel = HW'(i);
      end
    end
    note_last = ((nmask & (nmask - 1'b1)) == '0);
  end

  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    if (state == S_EMIT && !res_full) begin
      res_push = 1'b1;
      if (lval[0]) begin
        res_data.result_kind = RK_COUNT;
        res_data.cluster_out = lid[0];
        res_data.count_out = lcnt[0];
      end else begin
        res_data.result_kind = RK_TOTAL;
        res_data.cluster_out = NO_CLUSTER;
        res_data.count_out = total;
        res_data.last_result = 1'b1;
      end
    end else if (state == S_NOTE && !res_full) begin
      res_push = 1'b1;
      res_data.notice_x = cmd.px;
      res_data.notice_y = cmd.py;
      if (pend_add) begin
        res_data.result_kind = RK_ADD;
        res_data.cluster_out = cmd.cid;
        res_data.last_result = (nmask == '0);
      end else begin
        res_data.result_kind = RK_REMOVE;
        res_data.cluster_out = nid[sel];
        res_data.last_result = note_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      lval <= '0;
      pend_add <= 1'b0;
      nmask <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PIXELS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd <= q_data;
            z <= '0;
            total <= '0;
            lval <= '0;
            if (q_data.op == OP_CHECK) begin
              cur_x <= q_data.xs;
              cur_y <= q_data.ys;
              if (q_data.xs >= q_data.xe || q_data.ys >= q_data.ye) begin
                state <= S_EMIT;
              end else begin
                state <= S_RD;
              end
            end else begin
              cur_x <= CRD_W'(q_data.px);
              cur_y <= CRD_W'(q_data.py);
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= (cmd.op == OP_CHECK) ? S_SCAN : S_MOD;
        end
        S_SCAN: begin
          if (ts > cmd.fth) begin
            total <= total + 1'b1;
          end
          if (qualify) begin
            if (|eq) begin
              for (int i = 0; i < AREA_MAX; i++) begin
                if (eq[i]) begin
                  lcnt[i] <= lcnt[i] + 1'b1;
                end
              end
            end else begin
              for (int i = 1; i < AREA_MAX; i++) begin
                if (POS_W'(i) > pos) begin
                  lid[i] <= lid[i-1];
                  lcnt[i] <= lcnt[i-1];
                  lval[i] <= lval[i-1];
                end
              end
              for (int i = 0; i < AREA_MAX; i++) begin
                if (POS_W'(i) == pos) begin
                  lid[i] <= id;
                  lcnt[i] <= CNT_W'(1);
                  lval[i] <= 1'b1;
                end
              end
            end
          end
          if (32'(z) == QUEUE_DEPTH - 1) begin
            z <= '0;
            if (cur_y + 1'b1 < cmd.ye) begin
              cur_y <= cur_y + 1'b1;
              state <= S_RD;
            end else if (cur_x + 1'b1 < cmd.xe) begin
              cur_x <= cur_x + 1'b1;
              cur_y <= cmd.ys;
              state <= S_RD;
            end else begin
              state <= S_EMIT;
            end
          end else begin
            z <= z + 1'b1;
          end
        end
        S_EMIT: begin
          if (!res_full) begin
            if (lval[0]) begin
              for (int i = 0; i < AREA_MAX - 1; i++) begin
                lid[i] <= lid[i+1];
                lcnt[i] <= lcnt[i+1];
                lval[i] <= lval[i+1];
              end
              lval[AREA_MAX-1] <= 1'b0;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MOD: begin
          nid <= rd_id;
          nmask <= mod_mask;
          pend_add <= (cmd.op == OP_ADD) && (cmd.cid != NO_CLUSTER);
          if (((cmd.op == OP_ADD) && (cmd.cid != NO_CLUSTER)) || (mod_mask != '0)) begin
            state <= S_NOTE;
          end else begin
            state <= S_IDLE;
          end
        end
        S_NOTE: begin
          if (!res_full) begin
            if (pend_add) begin
              pend_add <= 1'b0;
              if (nmask == '0) begin
                state <= S_IDLE;
              end
            end else begin
              nmask[sel] <= 1'b0;
              if (note_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/event_pixel_neighbour_filter_top.sv
// ----------------------------------------------------------------------------
// Event pixel neighbour filter
// Background-activity filter with cluster membership over per-pixel rings of
// recent events.
// ----------------------------------------------------------------------------
// Channel    Handshake             Payload
// request    push / full           req (req_t)
// result     pop / empty           res (res_t)
// config     cfg_valid / cfg_ready cfg_index, cfg_data
//
// A check reads each pixel of the clipped neighbourhood through the store's
// read port and scans its QUEUE_DEPTH ring entries one at a time, then emits
// one result per cluster and a total. Add and flush rewrite one pixel's ring.
// After reset a clearing pass writes every pixel of the store while full stays
// high; configuration writes are taken throughout.
// A two-entry command queue and a two-entry result queue let each side stall.
// ----------------------------------------------------------------------------
`default_nettype none

module event_pixel_neighbour_filter_top import evpnf_pkg::*; #(
  parameter int FRAME_WIDTH = 256,
  parameter int FRAME_HEIGHT = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire req_t                 req,
  output logic                      empty,
  input  wire logic                 pop,
  output res_t                      res,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  logic clearing;
  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_wdata;
  cmd_t q_rdata;
  logic res_full;
  logic res_push;
  res_t res_wdata;

  evpnf_front #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .req(req),
    .clearing(clearing),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_wdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  evpnf_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wdata(q_wdata),
    .full(q_full),
    .pop(q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  evpnf_back #(
    .FRAME_WIDTH(FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .clearing(clearing),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_data(q_rdata),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_wdata)
  );

  evpnf_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .push(res_push),
    .wdata(res_wdata),
    .full(res_full),
    .pop(pop),
    .rdata(res),
    .empty(empty)
  );

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst) clearing |-> full)
    else $error("Request accepted during the clearing pass.");

  a_res_room: assert property (@(posedge clk) disable iff (rst) res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

  a_cmd_room: assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("Command pushed into a full command queue.");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (rst) clearing |-> !q_pop)
    else $error("Command taken during the clearing pass.");

endmodule

`default_nettype wire

>>> tb/event_pixel_neighbour_filter_top_tb.sv
// ----------------------------------------------------------------------------
// Event pixel neighbour filter testbench
// Drives check, add and flush requests with random idling on both queue
// sides, predicts every result from a private copy of the pixel rings and
// configuration, and compares each popped result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module event_pixel_neighbour_filter_top_tb;
  import evpnf_pkg::*;

  localparam int FW = 256;
  localparam int FH = 256;
  localparam int QD = 4;
  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 8'hFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  event_pixel_neighbour_filter_top u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .res(res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Private copy of the pixel rings; absent entries hold their reset value.
  logic [31:0] ring_stamp[int];
  logic [15:0] ring_member[int];
  int ring_head[int];
  logic [8:0] width_lim = 9'd256;
  logic [8:0] height_lim = 9'd256;
  logic [31:0] filter_win = 32'd10000;
  logic [31:0] cluster_win = 32'd10000;

  res_t pending_results[$];
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int checks_sent = 0;
  int adds_sent = 0;
  int flushes_sent = 0;
  int hold_cycles = 0;
  logic [31:0] now_stamp = 32'd0;

  function automatic logic [31:0] stamp_at(int k);
    return ring_stamp.exists(k) ? ring_stamp[k] : 32'd0;
  endfunction

  function automatic logic [15:0] member_at(int k);
    return ring_member.exists(k) ? ring_member[k] : NO_CLUSTER;
  endfunction

  function automatic void expect_result(logic [1:0] kind, logic [15:0] cl, int cnt,
                                        logic [7:0] nx, logic [7:0] ny, logic last);
    res_t r;
    r.result_kind = kind;
    r.cluster_out = cl;
    r.count_out = cnt[CNT_W-1:0];
    r.notice_x = nx;
    r.notice_y = ny;
    r.last_result = last;
    pending_results.push_back(r);
  endfunction

  function automatic logic [31:0] floor_minus(logic [31:0] t, logic [31:0] w);
    return (t >= w) ? t - w : 32'd0;
  endfunction

  function automatic void predict_filter(req_t r);
    int id_count[int];
    int total, xs, xe, ys, ye, wl, hl, base, h, k, n;
    logic [31:0] fth, cth;
    logic [15:0] old;
    total = 0;
    n = 0;
    base = (int'(r.pixel_y) * FW + int'(r.pixel_x)) * QD;
    case (r.req_type)
      REQ_CHECK: begin
        fth = floor_minus(r.time_value, filter_win);
        cth = floor_minus(r.time_value, cluster_win);
        wl = (width_lim < FW) ? int'(width_lim) : FW;
        hl = (height_lim < FH) ? int'(height_lim) : FH;
        xs = (r.pixel_x > 0) ? int'(r.pixel_x) - 1 : 0;
        ys = (r.pixel_y > 0) ? int'(r.pixel_y) - 1 : 0;
        xe = (int'(r.pixel_x) + 2 > wl) ? wl : int'(r.pixel_x) + 2;
        ye = (int'(r.pixel_y) + 2 > hl) ? hl : int'(r.pixel_y) + 2;
        for (int x = xs; x < xe; x++) begin
          for (int y = ys; y < ye; y++) begin
            for (int z = 0; z < QD; z++) begin
              k = (y * FW + x) * QD + z;
              if (stamp_at(k) > fth) total++;
              if (member_at(k) != NO_CLUSTER && stamp_at(k) > cth) begin
                if (id_count.exists(int'(member_at(k)))) id_count[int'(member_at(k))]++;
                else id_count[int'(member_at(k))] = 1;
              end
            end
          end
        end
        foreach (id_count[id]) expect_result(RK_COUNT, id[15:0], id_count[id], 8'd0, 8'd0, 1'b0);
        expect_result(RK_TOTAL, NO_CLUSTER, total, 8'd0, 8'd0, 1'b1);
      end
      REQ_ADD: begin
        h = ring_head.exists(base / QD) ? ring_head[base / QD] : 0;
        old = member_at(base + h);
        ring_stamp[base + h] = r.time_value;
        ring_member[base + h] = r.cluster_id;
        ring_head[base / QD] = (h + 1) % QD;
        if (r.cluster_id != NO_CLUSTER) begin
          expect_result(RK_ADD, r.cluster_id, 0, r.pixel_x, r.pixel_y, old == NO_CLUSTER);
        end
        if (old != NO_CLUSTER) expect_result(RK_REMOVE, old, 0, r.pixel_x, r.pixel_y, 1'b1);
      end
      REQ_FLUSH: begin
        for (int z = 0; z < QD; z++) begin
          if (member_at(base + z) != NO_CLUSTER && stamp_at(base + z) < r.time_value) begin
            if (n > 0) pending_results[pending_results.size() - 1].last_result = 1'b0;
            expect_result(RK_REMOVE, member_at(base + z), 0, r.pixel_x, r.pixel_y, 1'b1);
            ring_member[base + z] = NO_CLUSTER;
            n++;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_request(req_t r);
    int gap;
    logic ok;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    req = r;
    forever begin
      ok = !full;
      @(posedge clk);
      if (ok) break;
      @(negedge clk);
    end
    predict_filter(r);
    requests_sent++;
    case (r.req_type)
      REQ_CHECK: checks_sent++;
      REQ_ADD: adds_sent++;
      REQ_FLUSH: flushes_sent++;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    logic ok;
    push = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    forever begin
      ok = cfg_ready;
      @(posedge clk);
      if (ok) break;
      @(negedge clk);
    end
    case (idx)
      CFG_WIDTH: width_lim = value[8:0];
      CFG_HEIGHT: height_lim = value[8:0];
      CFG_FILTER: filter_win = value;
      CFG_CLUSTER: cluster_win = value;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    push = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic req_t make_request(logic [1:0] kind, int x, int y, logic [31:0] t,
                                        logic [15:0] cid);
    req_t r;
    r.req_type = kind;
    r.pixel_x = x[7:0];
    r.pixel_y = y[7:0];
    r.time_value = t;
    r.cluster_id = cid;
    return r;
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_side
    int stall;
    logic ok;
    res_t got, want;
    forever begin
      if (hold_cycles > 0) begin
        pop = 1'b0;
        while (hold_cycles > 0) begin
          @(negedge clk);
          hold_cycles--;
        end
      end
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        pop = 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop = 1'b1;
      forever begin
        ok = !empty;
        got = res;
        @(posedge clk);
        if (ok) break;
        @(negedge clk);
      end
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_configuration_at_reset();
    write_register(CFG_WIDTH, 32'd256);
    write_register(CFG_HEIGHT, 32'd256);
    write_register(CFG_FILTER, 32'd10000);
    write_register(CFG_CLUSTER, 32'd10000);
    write_register(CFG_UNUSED_LO, 32'd5);
    write_register(CFG_UNUSED_HI, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    send_request(make_request(REQ_CHECK, 0, 0, 32'd0, NO_CLUSTER));
    send_request(make_request(REQ_ADD, 0, 0, 32'd100, 16'd3));
    send_request(make_request(REQ_ADD, 1, 1, 32'd200, NO_CLUSTER));
    send_request(make_request(REQ_ADD, 0, 0, 32'd300, 16'd0));
    send_request(make_request(REQ_ADD, 0, 0, 32'd400, 16'hFFFE));
    send_request(make_request(REQ_ADD, 0, 0, 32'd500, 16'd3));
    send_request(make_request(REQ_ADD, 0, 0, 32'd600, 16'd7));
    send_request(make_request(REQ_ADD, 0, 0, 32'd700, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 1, 1, 32'd800, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 0, 0, 32'd20000, NO_CLUSTER));
    send_request(make_request(REQ_ADD, 255, 255, 32'hFFFF_FFFF, 16'd1));
    send_request(make_request(REQ_ADD, 254, 255, 32'hFFFF_FFF0, 16'd1));
    send_request(make_request(REQ_CHECK, 255, 255, 32'hFFFF_FFFF, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 254, 254, 32'd0, 16'hAAAA));
    send_request(make_request(REQ_FLUSH, 0, 0, 32'd550, NO_CLUSTER));
    send_request(make_request(REQ_FLUSH, 0, 0, 32'd550, NO_CLUSTER));
    send_request(make_request(REQ_FLUSH, 0, 0, 32'hFFFF_FFFF, NO_CLUSTER));
    send_request(make_request(REQ_FLUSH, 3, 3, 32'd0, NO_CLUSTER));
    send_request(make_request(REQ_SPARE, 0, 0, 32'h5555_5555, 16'h5555));
    send_request(make_request(REQ_CHECK, 0, 0, 32'd700, NO_CLUSTER));
    wait_idle();
  endtask

  task automatic test_window_extremes();
    write_register(CFG_FILTER, 32'd0);
    write_register(CFG_CLUSTER, 32'hFFFF_FFFF);
    send_request(make_request(REQ_CHECK, 0, 0, 32'd600, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 255, 254, 32'hFFFF_FFFF, NO_CLUSTER));
    wait_idle();
    write_register(CFG_FILTER, 32'hFFFF_FFFF);
    write_register(CFG_CLUSTER, 32'd0);
    send_request(make_request(REQ_CHECK, 1, 0, 32'hFFFF_FFFF, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 254, 255, 32'd5, NO_CLUSTER));
    wait_idle();
  endtask

  task automatic test_clipping();
    write_register(CFG_WIDTH, 32'd1);
    write_register(CFG_HEIGHT, 32'h0000_FE02);
    send_request(make_request(REQ_CHECK, 0, 0, 32'd700, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 1, 1, 32'd700, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 5, 9, 32'd700, NO_CLUSTER));
    wait_idle();
    write_register(CFG_WIDTH, 32'd255);
    write_register(CFG_HEIGHT, 32'd1);
    send_request(make_request(REQ_CHECK, 255, 0, 32'hFFFF_FFFF, NO_CLUSTER));
    send_request(make_request(REQ_CHECK, 254, 0, 32'hFFFF_FFFF, NO_CLUSTER));
    wait_idle();
  endtask

  task automatic random_burst(int count);
    int bx, by, pick;
    logic [1:0] kind;
    logic [15:0] cid;
    logic [31:0] t;
    bx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 250);
    by = $urandom_range(0, 1) ? 250 : $urandom_range(0, 250);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      kind = pick < 50 ? REQ_ADD : pick < 80 ? REQ_CHECK : pick < 95 ? REQ_FLUSH : REQ_SPARE;
      now_stamp += $urandom_range(0, 3000);
      t = now_stamp;
      if (kind == REQ_FLUSH) t = floor_minus(now_stamp, $urandom_range(0, 15000));
      if ($urandom_range(0, 9) == 0) t = $urandom;
      cid = $urandom_range(0, 6) == 0 ? NO_CLUSTER : 16'($urandom_range(0, 7));
      if ($urandom_range(0, 9) == 0) cid = 16'($urandom);
      if ($urandom_range(0, 4) == 0) begin
        send_request(make_request(kind, $urandom_range(0, 255), $urandom_range(0, 255), t, cid));
      end else begin
        send_request(make_request(kind, bx + $urandom_range(0, 5), by + $urandom_range(0, 5),
                                  t, cid));
      end
    end
  endtask

  task automatic test_random();
    write_register(CFG_WIDTH, 32'd256);
    write_register(CFG_HEIGHT, 32'd256);
    write_register(CFG_FILTER, 32'd8000);
    write_register(CFG_CLUSTER, 32'd5000);
    for (int b = 0; b < 2; b++) random_burst(20);
    wait_idle();
    write_register(CFG_WIDTH, 32'($urandom_range(1, 256)));
    write_register(CFG_HEIGHT, 32'($urandom_range(1, 256)));
    write_register(CFG_FILTER, 32'($urandom_range(0, 20000)));
    write_register(CFG_CLUSTER, 32'($urandom_range(0, 20000)));
    random_burst(20);
    wait_idle();
  endtask

  task automatic test_result_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      send_request(make_request(REQ_CHECK, 1 + i % 2, 1, 32'd600, NO_CLUSTER));
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_configuration_at_reset();
    test_directed();
    test_window_extremes();
    test_clipping();
    test_result_backpressure();
    test_random();
    $display("Sent %0d requests (%0d checks, %0d adds, %0d flushes), checked %0d results.",
             requests_sent, checks_sent, adds_sent, flushes_sent, results_seen);
    $display("Covered clipping, window extremes, ring wrap and a long result stall.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out.");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
